### src/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and constants for the segment intersection core
// Holds the result kind codes, the default widths, the tolerance factor
// and the output width.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int TOL_INV        = 10000;
    localparam int OUT_BITS       = 32;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_POINT   = 2'd1,
        KIND_OVERLAP = 2'd2,
        KIND_DEGEN   = 2'd3
    } t_kind;

endpackage

### src/ssi_div.sv
// ----------------------------------------------------------------------------
// ssi_div: pipelined fraction divider
// Computes floor(n * 2^FRAC / d) for 0 <= n < d, one quotient bit per stage.
// Carries a side word through the stages alongside the division.
// ----------------------------------------------------------------------------
module ssi_div
    import ssi_pkg::*;
#(
    parameter int NB   = 36,
    parameter int FRAC = FRAC_BITS_DEF,
    parameter int SB   = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [NB-1:0]   i_num,
    input  logic [NB-1:0]   i_den,
    input  logic [SB-1:0]   i_side,
    output logic            o_valid,
    output logic [FRAC-1:0] o_quo,
    output logic [SB-1:0]   o_side
);

    logic            r_vld [FRAC];
    logic [NB:0]     r_rem [FRAC];
    logic [NB-1:0]   r_den [FRAC];
    logic [FRAC-1:0] r_quo [FRAC];
    logic [SB-1:0]   r_sd  [FRAC];

    for (genvar g = 0; g < FRAC; g++) begin : g_stage
        logic            s_vld;
        logic [NB:0]     s_rem;
        logic [NB-1:0]   s_den;
        logic [FRAC-1:0] s_quo;
        logic [SB-1:0]   s_sd;
        logic [NB+1:0]   n_sh;
        logic            n_ge;
        if (g == 0) begin : g_in
            assign s_vld = i_valid;
            assign s_rem = {1'b0, i_num};
            assign s_den = i_den;
            assign s_quo = '0;
            assign s_sd  = i_side;
        end else begin : g_mid
            assign s_vld = r_vld[g-1];
            assign s_rem = r_rem[g-1];
            assign s_den = r_den[g-1];
            assign s_quo = r_quo[g-1];
            assign s_sd  = r_sd[g-1];
        end
        assign n_sh = {s_rem, 1'b0};
        assign n_ge = n_sh >= {2'b00, s_den};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= s_vld;
            end
            if (i_en) begin
                r_rem[g] <= n_ge ? (NB+1)'(n_sh - {2'b00, s_den}) : n_sh[NB:0];
                r_den[g] <= s_den;
                r_quo[g] <= {s_quo[FRAC-2:0], n_ge};
                r_sd[g]  <= s_sd;
            end
        end
    end

    assign o_valid = r_vld[FRAC-1];
    assign o_quo   = r_quo[FRAC-1];
    assign o_side  = r_sd[FRAC-1];

endmodule

### src/ssi_front.sv
// ----------------------------------------------------------------------------
// ssi_front: classify stage
// Forms deltas, products and tolerance tests over registered stages and
// emits a word holding the kind, the division operands and the point base.
// ----------------------------------------------------------------------------
module ssi_front
    import ssi_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF,
    parameter int NB = 2*CB+5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CB-1:0] i_ax0, i_ay0, i_ax1, i_ay1,
    input  logic signed [CB-1:0] i_bx0, i_by0, i_bx1, i_by1,
    output logic                 o_valid,
    output t_kind                o_kind,
    output logic                 o_div0,
    output logic                 o_div1,
    output logic [NB-1:0]        o_n0,
    output logic [NB-1:0]        o_n1,
    output logic [NB-1:0]        o_den,
    output logic                 o_full0,
    output logic                 o_full1,
    output logic signed [CB-1:0] o_px, o_py,
    output logic signed [CB:0]   o_dx, o_dy
);

    localparam int DB = CB + 1;
    localparam int PB = 2*DB + 1;
    localparam int SB = 2*PB + 16;
    localparam int WB = 2*PB + 2;

    // stage 1: deltas
    logic                  r1_v;
    logic signed [DB-1:0]  r1_dx, r1_dy, r1_ex, r1_ey, r1_fx, r1_fy;
    logic signed [CB-1:0]  r1_px, r1_py;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (i_en) r1_v <= i_valid;
        if (i_en) begin
            r1_px <= i_ax0; r1_py <= i_ay0;
            r1_dx <= DB'(i_ax1) - DB'(i_ax0);
            r1_dy <= DB'(i_ay1) - DB'(i_ay0);
            r1_ex <= DB'(i_bx0) - DB'(i_ax0);
            r1_ey <= DB'(i_by0) - DB'(i_ay0);
            r1_fx <= DB'(i_bx1) - DB'(i_bx0);
            r1_fy <= DB'(i_by1) - DB'(i_by0);
        end
    end

    // stage 2: pairwise products
    logic                  r2_v;
    logic signed [PB-1:0]  r2_len0, r2_len1, r2_lene, r2_kr, r2_ns, r2_nt, r2_n0, r2_df;
    logic signed [CB-1:0]  r2_px, r2_py;
    logic signed [DB-1:0]  r2_dx, r2_dy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (i_en) r2_v <= r1_v;
        if (i_en) begin
            r2_px <= r1_px; r2_py <= r1_py; r2_dx <= r1_dx; r2_dy <= r1_dy;
            r2_len0 <= PB'(r1_dx*r1_dx) + PB'(r1_dy*r1_dy);
            r2_len1 <= PB'(r1_fx*r1_fx) + PB'(r1_fy*r1_fy);
            r2_lene <= PB'(r1_ex*r1_ex) + PB'(r1_ey*r1_ey);
            r2_kr   <= PB'(r1_dx*r1_fy) - PB'(r1_dy*r1_fx);
            r2_ns   <= PB'(r1_ex*r1_fy) - PB'(r1_ey*r1_fx);
            r2_nt   <= PB'(r1_ex*r1_dy) - PB'(r1_ey*r1_dx);
            r2_n0   <= PB'(r1_dx*r1_ex) + PB'(r1_dy*r1_ey);
            r2_df   <= PB'(r1_dx*r1_fx) + PB'(r1_dy*r1_fy);
        end
    end

    // stage 3: squares for tolerance tests, sign normalize
    logic                  r3_v;
    logic [WB-1:0]         r3_k2a, r3_k2b, r3_ra, r3_rb;
    logic signed [PB-1:0]  r3_ns, r3_nt, r3_k, r3_n0, r3_n1, r3_len0;
    logic signed [CB-1:0]  r3_px, r3_py;
    logic signed [DB-1:0]  r3_dx, r3_dy;
    logic [PB-1:0]         n3_akr, n3_ant;
    assign n3_akr = r2_kr[PB-1] ? PB'(-r2_kr) : PB'(r2_kr);
    assign n3_ant = r2_nt[PB-1] ? PB'(-r2_nt) : PB'(r2_nt);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (i_en) r3_v <= r2_v;
        if (i_en) begin
            r3_px <= r2_px; r3_py <= r2_py; r3_dx <= r2_dx; r3_dy <= r2_dy;
            r3_k2a <= WB'(n3_akr) * WB'(n3_akr);
            r3_k2b <= WB'(n3_ant) * WB'(n3_ant);
            r3_ra  <= WB'(unsigned'(r2_len0)) * WB'(unsigned'(r2_len1));
            r3_rb  <= WB'(unsigned'(r2_len0)) * WB'(unsigned'(r2_lene));
            r3_k   <= PB'(n3_akr);
            r3_ns  <= r2_kr[PB-1] ? PB'(-r2_ns) : r2_ns;
            r3_nt  <= r2_kr[PB-1] ? PB'(-r2_nt) : r2_nt;
            r3_n0  <= r2_n0;
            r3_n1  <= PB'(r2_n0 + r2_df);
            r3_len0 <= r2_len0;
        end
    end

    // stage 4: classify
    logic [SB-1:0] n_la, n_lb;
    logic          n_cross, n_off;
    logic signed [PB-1:0] n_min, n_max;
    assign n_la    = SB'(r3_k2a) * SB'(TOL_INV);
    assign n_lb    = SB'(r3_k2b) * SB'(TOL_INV);
    assign n_cross = n_la > SB'(r3_ra);
    assign n_off   = n_lb > SB'(r3_rb);
    assign n_min   = (r3_n0 < r3_n1) ? r3_n0 : r3_n1;
    assign n_max   = (r3_n0 > r3_n1) ? r3_n0 : r3_n1;

    t_kind          n_kind;
    logic           n_d0, n_d1, n_f0, n_f1;
    logic [NB-1:0]  n_a, n_b, n_den;
    always_comb begin
        n_kind = KIND_NONE;
        n_d0 = 1'b0; n_d1 = 1'b0; n_f0 = 1'b0; n_f1 = 1'b0;
        n_a = '0; n_b = '0; n_den = NB'(unsigned'(r3_len0));
        priority if (r3_len0 == '0) begin
            n_kind = KIND_DEGEN;
        end else if (n_cross) begin
            n_den = NB'(unsigned'(r3_k));
            if (!(r3_ns < 0 || r3_ns > r3_k || r3_nt < 0 || r3_nt > r3_k)) begin
                n_kind = KIND_POINT;
                if (r3_ns == r3_k) n_f0 = 1'b1;
                else begin n_d0 = 1'b1; n_a = NB'(unsigned'(r3_ns)); end
            end
        end else if (n_off || n_min > r3_len0 || n_max < 0) begin
            n_kind = KIND_NONE;
        end else if (n_min < r3_len0) begin
            if (n_max > 0) begin
                n_kind = KIND_OVERLAP;
                if (n_min >= 0) begin n_d0 = 1'b1; n_a = NB'(unsigned'(n_min)); end
                if (n_max >= r3_len0) n_f1 = 1'b1;
                else begin n_d1 = 1'b1; n_b = NB'(unsigned'(n_max)); end
            end else begin
                n_kind = KIND_POINT;
            end
        end else begin
            n_kind = KIND_POINT;
            n_f0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (i_en) o_valid <= r3_v;
        if (i_en) begin
            o_kind <= n_kind; o_div0 <= n_d0; o_div1 <= n_d1;
            o_full0 <= n_f0; o_full1 <= n_f1;
            o_n0 <= n_a; o_n1 <= n_b; o_den <= n_den;
            o_px <= r3_px; o_py <= r3_py; o_dx <= r3_dx; o_dy <= r3_dy;
        end
    end

endmodule

### src/ssi_back.sv
// ----------------------------------------------------------------------------
// ssi_back: point back end
// Divides both interval ends in two pipelined dividers and places the
// points as P + q*D, truncated to 32 bits, into a registered word.
// ----------------------------------------------------------------------------
module ssi_back
    import ssi_pkg::*;
#(
    parameter int CB   = COORD_BITS_DEF,
    parameter int FRAC = FRAC_BITS_DEF,
    parameter int NB   = 2*CB+5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_kind                i_kind,
    input  logic                 i_div0,
    input  logic                 i_div1,
    input  logic [NB-1:0]        i_n0,
    input  logic [NB-1:0]        i_n1,
    input  logic [NB-1:0]        i_den,
    input  logic                 i_full0,
    input  logic                 i_full1,
    input  logic signed [CB-1:0] i_px, i_py,
    input  logic signed [CB:0]   i_dx, i_dy,
    output logic                 o_valid,
    output t_kind                o_kind,
    output logic signed [OUT_BITS-1:0] o_x0, o_y0, o_x1, o_y1
);

    localparam int SB0 = 2 + 4;
    localparam int SB1 = 2*CB + 2*(CB+1);
    localparam int QB  = FRAC + 1;
    localparam int MB  = QB + CB + 2 + FRAC;

    // kind and flags ride in the first divider, the point base in the second
    logic [SB0-1:0] n_side0, w_side0;
    logic [SB1-1:0] n_side1, w_side1;
    logic [FRAC-1:0] w_q0, w_q1;
    logic w_v, w_v1;
    assign n_side0 = {i_kind, i_div0, i_div1, i_full0, i_full1};
    assign n_side1 = {i_px, i_py, i_dx, i_dy};

    ssi_div #(.NB(NB), .FRAC(FRAC), .SB(SB0)) u_div0 (
        .i_clk, .i_rst_n, .i_en, .i_valid,
        .i_num(i_n0), .i_den(i_den), .i_side(n_side0),
        .o_valid(w_v), .o_quo(w_q0), .o_side(w_side0)
    );
    ssi_div #(.NB(NB), .FRAC(FRAC), .SB(SB1)) u_div1 (
        .i_clk, .i_rst_n, .i_en, .i_valid,
        .i_num(i_n1), .i_den(i_den), .i_side(n_side1),
        .o_valid(w_v1), .o_quo(w_q1), .o_side(w_side1)
    );

    t_kind k_kind;
    logic k_d0, k_d1, k_f0, k_f1;
    logic signed [CB-1:0] k_px, k_py;
    logic signed [CB:0] k_dx, k_dy;
    assign k_kind = t_kind'(w_side0[SB0-1:SB0-2]);
    assign {k_d0, k_d1, k_f0, k_f1} = w_side0[3:0];
    assign {k_px, k_py, k_dx, k_dy} = w_side1;

    logic signed [QB:0] n_qa, n_qb;
    assign n_qa = k_f0 ? (QB+1)'(1 << FRAC) : (k_d0 ? {2'b00, w_q0} : '0);
    assign n_qb = k_f1 ? (QB+1)'(1 << FRAC) : (k_d1 ? {2'b00, w_q1} : '0);

    // stage a: products
    logic r_v;
    t_kind r_kind;
    logic signed [MB-1:0] r_mx0, r_my0, r_mx1, r_my1;
    logic signed [CB-1:0] r_px, r_py;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= 1'b0;
        else if (i_en) r_v <= w_v & w_v1;
        if (i_en) begin
            r_kind <= k_kind; r_px <= k_px; r_py <= k_py;
            r_mx0 <= MB'(n_qa) * MB'(k_dx);
            r_my0 <= MB'(n_qa) * MB'(k_dy);
            r_mx1 <= MB'(n_qb) * MB'(k_dx);
            r_my1 <= MB'(n_qb) * MB'(k_dy);
        end
    end

    // stage b: add base, zero per kind
    logic signed [MB-1:0] n_bx, n_by;
    assign n_bx = MB'(r_px) <<< FRAC;
    assign n_by = MB'(r_py) <<< FRAC;
    logic n_pt, n_ov;
    assign n_pt = (r_kind == KIND_POINT) || (r_kind == KIND_OVERLAP);
    assign n_ov = r_kind == KIND_OVERLAP;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (i_en) o_valid <= r_v;
        if (i_en) begin
            o_kind <= r_kind;
            o_x0 <= n_pt ? OUT_BITS'(n_bx + r_mx0) : '0;
            o_y0 <= n_pt ? OUT_BITS'(n_by + r_my0) : '0;
            o_x1 <= n_ov ? OUT_BITS'(n_bx + r_mx1) : '0;
            o_y1 <= n_ov ? OUT_BITS'(n_by + r_my1) : '0;
        end
    end

endmodule

### src/ssi_fifo.sv
// ----------------------------------------------------------------------------
// ssi_fifo: result queue
// Holds finished words so the pipelines can drain while the sink stalls.
// ----------------------------------------------------------------------------
module ssi_fifo
    import ssi_pkg::*;
#(
    parameter int W     = 130,
    parameter int DEPTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AB = $clog2(DEPTH);
    logic [W-1:0]  r_mem [DEPTH];
    logic [AB-1:0] r_wp, r_rp;
    logic [AB:0]   r_cnt;
    logic [W-1:0]  r_out;
    logic          r_ov;
    logic          n_take;

    // output register is refilled when empty or being popped
    assign n_take = (r_cnt != '0) && (!r_ov || i_pop);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (n_take) r_out <= r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_ov <= 1'b0;
        end else begin
            if (i_push) r_wp <= AB'(r_wp + 1'b1);
            if (n_take) r_rp <= AB'(r_rp + 1'b1);
            r_cnt <= r_cnt + (AB+1)'(i_push) - (AB+1)'(n_take);
            if (n_take) r_ov <= 1'b1;
            else if (i_pop) r_ov <= 1'b0;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign o_count = ($clog2(DEPTH+1))'(r_cnt + (AB+1)'(r_ov));

endmodule

### src/segment_segment_intersect_2d_core.sv
// ----------------------------------------------------------------------------
// segment_segment_intersect_2d_core: 2D segment pair intersection
// Path: 4 front stages + FRAC_BITS divider stages + 2 place stages + queue
// (write, registered read). Throughput: one word per cycle while o_stall is
// low, set by the fully pipelined front end and the per-bit divider stages.
// Reset: synchronous active low; clears valid bits, pointers and counts only.
// ----------------------------------------------------------------------------
module segment_segment_intersect_2d_core
    import ssi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic signed [COORD_BITS-1:0] i_a_start_x, i_a_start_y,
    input  logic signed [COORD_BITS-1:0] i_a_end_x, i_a_end_y,
    input  logic signed [COORD_BITS-1:0] i_b_start_x, i_b_start_y,
    input  logic signed [COORD_BITS-1:0] i_b_end_x, i_b_end_y,
    output logic o_valid,
    input  logic i_stall,
    output logic [1:0] o_kind,
    output logic signed [OUT_BITS-1:0] o_first_x, o_first_y,
    output logic signed [OUT_BITS-1:0] o_second_x, o_second_y
);

    localparam int NB    = 2*COORD_BITS + 5;
    localparam int LAT   = 4 + FRAC_BITS + 2;
    localparam int DEPTH = 1 << $clog2(LAT + 4);
    localparam int W     = 2 + 4*OUT_BITS;
    localparam int CW    = $clog2(DEPTH+1);

    // Pipelines always advance; accept only when the queue has room for
    // every word already in flight plus this one.
    logic r_fv;
    logic [CW-1:0] w_cnt;
    logic [$clog2(LAT+2)-1:0] r_fly;
    logic w_acc, w_bv, w_pop;

    assign o_stall = (32'(w_cnt) + 32'(r_fly)) >= (DEPTH - 1);
    assign w_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fly <= '0;
        else r_fly <= r_fly + ($clog2(LAT+2))'(w_acc) - ($clog2(LAT+2))'(w_bv);
    end

    t_kind f_kind;
    logic f_d0, f_d1, f_f0, f_f1;
    logic [NB-1:0] f_n0, f_n1, f_den;
    logic signed [COORD_BITS-1:0] f_px, f_py;
    logic signed [COORD_BITS:0] f_dx, f_dy;

    ssi_front #(.CB(COORD_BITS), .NB(NB)) u_front (
        .i_clk, .i_rst_n, .i_en(1'b1), .i_valid(w_acc),
        .i_ax0(i_a_start_x), .i_ay0(i_a_start_y),
        .i_ax1(i_a_end_x), .i_ay1(i_a_end_y),
        .i_bx0(i_b_start_x), .i_by0(i_b_start_y),
        .i_bx1(i_b_end_x), .i_by1(i_b_end_y),
        .o_valid(r_fv), .o_kind(f_kind), .o_div0(f_d0), .o_div1(f_d1),
        .o_n0(f_n0), .o_n1(f_n1), .o_den(f_den), .o_full0(f_f0), .o_full1(f_f1),
        .o_px(f_px), .o_py(f_py), .o_dx(f_dx), .o_dy(f_dy)
    );

    t_kind b_kind;
    logic signed [OUT_BITS-1:0] b_x0, b_y0, b_x1, b_y1;

    ssi_back #(.CB(COORD_BITS), .FRAC(FRAC_BITS), .NB(NB)) u_back (
        .i_clk, .i_rst_n, .i_en(1'b1), .i_valid(r_fv),
        .i_kind(f_kind), .i_div0(f_d0), .i_div1(f_d1),
        .i_n0(f_n0), .i_n1(f_n1), .i_den(f_den), .i_full0(f_f0), .i_full1(f_f1),
        .i_px(f_px), .i_py(f_py), .i_dx(f_dx), .i_dy(f_dy),
        .o_valid(w_bv), .o_kind(b_kind),
        .o_x0(b_x0), .o_y0(b_y0), .o_x1(b_x1), .o_y1(b_y1)
    );

    logic [W-1:0] w_out;
    assign w_pop = o_valid && !i_stall;

    ssi_fifo #(.W(W), .DEPTH(DEPTH)) u_fifo (
        .i_clk, .i_rst_n, .i_push(w_bv),
        .i_data({b_kind, b_x0, b_y0, b_x1, b_y1}),
        .i_pop(w_pop), .o_valid(o_valid), .o_data(w_out), .o_count(w_cnt)
    );

    assign {o_kind, o_first_x, o_first_y, o_second_x, o_second_y} = w_out;

endmodule
